// File: rtl/bdm_pkg.sv
// shared types, constants and register codes for the 5x5 bayer demosaic
package bdm_pkg;

  localparam int PIX_W   = 12;
  localparam int CFG_W   = 13;
  localparam int PHASE_W = 2;
  localparam int IDX_W   = 2;
  localparam int ROW_W   = 13;
  // kernel sums reach about sixteen times full scale, plus sign
  localparam int SUM_W   = PIX_W + 6;
  localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};

  localparam logic [CFG_W-1:0]   WIDTH_RST  = 13'd1920;
  localparam logic [CFG_W-1:0]   HEIGHT_RST = 13'd1080;
  localparam logic [PHASE_W-1:0] PHASE_RST  = 2'd0;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [4:0] col_t;
  typedef pix_t [3:0] line_t;
  typedef col_t [4:0] win_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  typedef enum logic [IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_BAYER_PHASE  = 2'd2,
    REG_ENABLE       = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SITE_RED   = 2'd0,
    SITE_GR    = 2'd1,
    SITE_GB    = 2'd2,
    SITE_BLUE  = 2'd3
  } site_t;

  typedef struct packed {
    logic  emit;
    logic  active;
    site_t site;
  } ctrl_t;

  typedef struct packed {
    logic req_type;
    pix_t raw_pixel;
  } in_word_t;

  typedef struct packed {
    pix_t red;
    pix_t green;
    pix_t blue;
  } out_word_t;

endpackage

// File: rtl/bayer_demosaic_5x5.sv
// top level: config registers, raster counters, pipeline control and output register
// path: an accepted word moves through stage 1, stage 2 and the output register
// one word per cycle unless stalled; the line store has one read and one write port
// reset: synchronous; config returns to defaults, counters and window clear,
// then a clearing pass zeroes every line store column with in_stall high
// pad words and words that give no result still take one pipeline slot each
module bayer_demosaic_5x5 #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  bdm_pkg::in_word_t              in_word,
  output logic                           out_valid,
  input  logic                           out_stall,
  output bdm_pkg::out_word_t             out_word,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bdm_pkg::IDX_W-1:0]      cfg_index,
  input  logic [bdm_pkg::CFG_W-1:0]      cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int LW = bdm_pkg::CFG_W + 1;

  // config
  logic [bdm_pkg::CFG_W-1:0]   frame_width_r, frame_height_r;
  logic [bdm_pkg::PHASE_W-1:0] bayer_phase_r;
  logic                        enable_r;

  // raster position of the next pixel
  logic [CW-1:0]               col_r, col_nxt;
  logic [bdm_pkg::ROW_W-1:0]   row_r, row_nxt;
  logic [LW-1:0]               wlim, hlim, col_p1, row_p1;

  // stage 1: accepted word, line store read in flight
  logic                        s1_valid_r, s1_valid_nxt;
  logic                        s1_upd_r;
  bdm_pkg::pix_t               s1_px_r;
  logic [CW-1:0]               s1_col_r;
  bdm_pkg::ctrl_t              s1_ctrl_r, s1_ctrl_nxt;
  logic                        byp_r;
  bdm_pkg::line_t              byp_data_r;

  // stage 2: window holds this word's neighborhood
  logic                        s2_valid_r, s2_valid_nxt;
  bdm_pkg::ctrl_t              s2_ctrl_r;

  logic                        out_valid_r, out_valid_nxt;
  bdm_pkg::out_word_t          out_word_r;

  logic                        acc, out_free, s2_adv, s2_free, s1_adv, s1_free;
  logic                        ls_busy, ls_wr;
  bdm_pkg::line_t              ls_rd_data, ls_old, ls_wr_data;
  bdm_pkg::col_t               new_col;
  bdm_pkg::win_t               win;
  bdm_pkg::out_word_t          rgb;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= bdm_pkg::WIDTH_RST;
      frame_height_r <= bdm_pkg::HEIGHT_RST;
      bayer_phase_r  <= bdm_pkg::PHASE_RST;
      enable_r       <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (bdm_pkg::cfg_reg_t'(cfg_index))
        bdm_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        bdm_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        bdm_pkg::REG_BAYER_PHASE:  bayer_phase_r  <= cfg_data[bdm_pkg::PHASE_W-1:0];
        bdm_pkg::REG_ENABLE:       enable_r       <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // handshake chain, each stage moves when the next one has room
  assign out_free = !out_valid_r || !out_stall;
  assign s2_adv   = s2_valid_r && out_free;
  assign s2_free  = !s2_valid_r || s2_adv;
  assign s1_adv   = s1_valid_r && s2_free;
  assign s1_free  = !s1_valid_r || s1_adv;
  assign in_stall = ls_busy || !s1_free;
  assign acc      = in_valid && !in_stall;

  // geometry limits, out-of-range widths clamp
  always_comb begin
    if (frame_width_r == '0) begin
      wlim = LW'(1);
    end else if ({1'b0, frame_width_r} > LW'(MAX_WIDTH)) begin
      wlim = LW'(MAX_WIDTH);
    end else begin
      wlim = {1'b0, frame_width_r};
    end
    hlim   = (frame_height_r == '0) ? LW'(1) : {1'b0, frame_height_r};
    col_p1 = LW'(col_r) + 1'b1;
    row_p1 = {1'b0, row_r} + 1'b1;

    col_nxt = col_r;
    row_nxt = row_r;
    if (acc && !in_word.req_type) begin
      if (col_p1 >= wlim) begin
        col_nxt = '0;
        row_nxt = (row_p1 >= hlim) ? '0 : row_p1[bdm_pkg::ROW_W-1:0];
      end else begin
        col_nxt = col_p1[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_comb begin
    s1_ctrl_nxt.site = bdm_pkg::site_t'({row_r[0], col_r[0]} ^ bayer_phase_r);
    if (in_word.req_type) begin
      s1_ctrl_nxt.emit   = 1'b1;
      s1_ctrl_nxt.active = 1'b0;
    end else begin
      s1_ctrl_nxt.emit   = (row_r > bdm_pkg::ROW_W'(2))
                        || (row_r == bdm_pkg::ROW_W'(2) && col_r > CW'(1));
      s1_ctrl_nxt.active = enable_r && row_r > bdm_pkg::ROW_W'(3) && col_r > CW'(3);
    end
  end

  // line store read-modify-write happens as stage 1 moves to stage 2
  assign ls_wr  = s1_adv && s1_upd_r;
  assign ls_old = byp_r ? byp_data_r : ls_rd_data;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      new_col[i] = ls_old[i];
    end
    new_col[4] = s1_px_r;
    for (int i = 0; i < 4; i++) begin
      ls_wr_data[i] = new_col[i+1];
    end
  end

  assign s1_valid_nxt = acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_upd_r   <= !in_word.req_type && enable_r;
      s1_px_r    <= in_word.raw_pixel;
      s1_col_r   <= col_r;
      s1_ctrl_r  <= s1_ctrl_nxt;
      // same column written this edge: the read returns stale data
      byp_r      <= ls_wr && (s1_col_r == col_r);
      byp_data_r <= ls_wr_data;
    end
  end

  assign s2_valid_nxt = s1_adv ? 1'b1 : (s2_adv ? 1'b0 : s2_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_ctrl_r <= s1_ctrl_r;
    end
  end

  // words that give no result are dropped here
  always_comb begin
    if (s2_adv && s2_ctrl_r.emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s2_ctrl_r.emit) begin
      out_word_r <= rgb;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  bdm_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (acc),
    .rd_addr (col_r),
    .rd_data (ls_rd_data),
    .wr_en   (ls_wr),
    .wr_addr (s1_col_r),
    .wr_data (ls_wr_data),
    .busy    (ls_busy)
  );

  bdm_window u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (ls_wr),
    .col_in (new_col),
    .win    (win)
  );

  bdm_interp u_interp (
    .win  (win),
    .ctrl (s2_ctrl_r),
    .rgb  (rgb)
  );

endmodule

// File: rtl/bdm_line_store.sv
// four line stores packed in one memory word per column, cleared after reset
module bdm_line_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output bdm_pkg::line_t      rd_data,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  bdm_pkg::line_t      wr_data,
  output logic                busy
);

  bdm_pkg::line_t mem [DEPTH];
  bdm_pkg::line_t rd_data_r;
  logic [AW-1:0]  clr_cnt_r;
  logic           busy_r;

  // clearing pass: one column per cycle after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      clr_cnt_r <= '0;
    end else if (busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == AW'(DEPTH - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = busy_r;

endmodule

// File: rtl/bdm_window.sv
// 5x5 sample window, shifts one column left when a new column loads
module bdm_window (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  bdm_pkg::col_t col_in,
  output bdm_pkg::win_t win
);

  bdm_pkg::win_t win_r;
  bdm_pkg::win_t win_nxt;

  always_comb begin
    win_nxt = win_r;
    for (int i = 0; i < 5; i++) begin
      for (int j = 0; j < 4; j++) begin
        win_nxt[i][j] = win_r[i][j+1];
      end
      win_nxt[i][4] = col_in[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (load) begin
      win_r <= win_nxt;
    end
  end

  assign win = win_r;

endmodule

// File: rtl/bdm_interp.sv
// gradient-corrected 5x5 kernels, site select and clipping
module bdm_interp (
  input  bdm_pkg::win_t     win,
  input  bdm_pkg::ctrl_t    ctrl,
  output bdm_pkg::out_word_t rgb
);

  bdm_pkg::sum_t c, n02, n20, n42, n24, n12, n21, n32, n23;
  bdm_pkg::sum_t d11, d13, d31, d33;
  bdm_pkg::sum_t s_cross, g_sum, opp_sum, hor_sum, ver_sum;
  bdm_pkg::pix_t g_pix, opp_pix, hor_pix, ver_pix;

  function automatic bdm_pkg::sum_t ext(input bdm_pkg::pix_t p);
    ext = $signed({{(bdm_pkg::SUM_W - bdm_pkg::PIX_W){1'b0}}, p});
  endfunction

  // divide by 8 then clip; any negative sum clips to zero either way
  function automatic bdm_pkg::pix_t clip8(input bdm_pkg::sum_t t);
    bdm_pkg::sum_t q;
    q = t >>> 3;
    if (t[bdm_pkg::SUM_W-1]) begin
      clip8 = '0;
    end else if (q > ext(bdm_pkg::PIX_MAX)) begin
      clip8 = bdm_pkg::PIX_MAX;
    end else begin
      clip8 = q[bdm_pkg::PIX_W-1:0];
    end
  endfunction

  always_comb begin
    c   = ext(win[2][2]);
    n02 = ext(win[0][2]);
    n20 = ext(win[2][0]);
    n42 = ext(win[4][2]);
    n24 = ext(win[2][4]);
    n12 = ext(win[1][2]);
    n21 = ext(win[2][1]);
    n32 = ext(win[3][2]);
    n23 = ext(win[2][3]);
    d11 = ext(win[1][1]);
    d13 = ext(win[1][3]);
    d31 = ext(win[3][1]);
    d33 = ext(win[3][3]);

    s_cross = n02 + n20 + n42 + n24;
    g_sum   = (c <<< 2) - s_cross + ((n32 + n23 + n12 + n21) <<< 1);
    // three halves of the far cross; the sum can go negative and then clips to zero
    opp_sum = (c <<< 2) + (c <<< 1) - ((s_cross + (s_cross <<< 1)) >>> 1)
            + ((d11 + d13 + d31 + d33) <<< 1);
    hor_sum = (c <<< 2) + c - n20 - d11 - d31 - d13 - d33 - n24
            + ((n02 + n42) >>> 1) + ((n21 + n23) <<< 2);
    ver_sum = (c <<< 2) + c - n02 - d11 - d13 - n42 - d31 - d33
            + ((n20 + n24) >>> 1) + ((n12 + n32) <<< 2);

    g_pix   = clip8(g_sum);
    opp_pix = clip8(opp_sum);
    hor_pix = clip8(hor_sum);
    ver_pix = clip8(ver_sum);

    rgb = '0;
    if (ctrl.active) begin
      case (ctrl.site)
        bdm_pkg::SITE_RED: begin
          rgb.red   = win[2][2];
          rgb.green = g_pix;
          rgb.blue  = opp_pix;
        end
        bdm_pkg::SITE_GR: begin
          rgb.red   = hor_pix;
          rgb.green = win[2][2];
          rgb.blue  = ver_pix;
        end
        bdm_pkg::SITE_GB: begin
          rgb.red   = ver_pix;
          rgb.green = win[2][2];
          rgb.blue  = hor_pix;
        end
        bdm_pkg::SITE_BLUE: begin
          rgb.red   = opp_pix;
          rgb.green = g_pix;
          rgb.blue  = win[2][2];
        end
        default: begin
          rgb = '0;
        end
      endcase
    end
  end

endmodule
